// ----- rtl/core/cheapest_window_start_search_macros.svh -----
// Assertion macros for the cheapest window start search block.
// Used by modules that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef CHEAPEST_WINDOW_START_SEARCH_MACROS_SVH
`define CHEAPEST_WINDOW_START_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define CWSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cwss check failed");
`define CWSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cwss check failed");
`else
`define CWSS_ASSERT_NOW(label, ante, cons)
`define CWSS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/cwss_pkg.sv -----
// Shared types, constants and helpers for the cheapest window start search.
// No dependencies; imported by every other file of the block except the assertion macros header.
`timescale 1ns / 1ps
package cwss_pkg;

    localparam int TIME_W           = 32;
    localparam int PRICE_W          = 24;
    localparam int WIN_W            = 3;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 32;
    localparam int MAX_WINDOW       = 6;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int MIN_ENTRIES      = 2;
    localparam int SPAN_W           = 9;
    localparam int SUM_W            = PRICE_W + $clog2(MAX_WINDOW + 1);
    localparam int CNT_MAX          = (MAX_WINDOW > MIN_ENTRIES) ? MAX_WINDOW : MIN_ENTRIES;
    localparam int CNT_W            = $clog2(CNT_MAX + 1);
    localparam int IDX_W            = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    typedef logic        [TIME_W-1:0]  t_time;
    typedef logic signed [PRICE_W-1:0] t_price;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic        [CNT_W-1:0]   t_cnt;
    typedef logic        [WIN_W-1:0]   t_win;
    typedef logic        [SPAN_W-1:0]  t_span;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_HOURS = 2'd0,
        CFG_START_TIME   = 2'd1,
        CFG_STOP_TIME    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_win  window_hours;
        t_time earliest_time;
        t_time stop_time;
    } t_cfg;

    // Contents of one window cell: entry start time and partial price sum.
    typedef struct packed {
        t_time tstart;
        t_sum  acc;
    } t_cell;

    typedef struct packed {
        logic valid;
        logic last;
        t_cnt cnt;
    } t_stage;

    typedef struct packed {
        t_time first_time;
        t_sum  sum;
    } t_cand;

    function automatic t_win window_len(input t_win wh);
        t_win w;
        w = wh;
        if (32'(wh) > MAX_WINDOW) begin
            w = WIN_W'(MAX_WINDOW);
        end
        return w;
    endfunction

    function automatic t_span window_span(input t_win w);
        t_span s;
        s = SPAN_W'(w) * SPAN_W'(MINUTES_PER_HOUR);
        return s;
    endfunction

endpackage

// ----- rtl/core/cwss_in_if.sv -----
// Input channel of the cheapest window start search: one price entry per beat.
// Depends on cwss_pkg for field widths.
`timescale 1ns / 1ps
interface cwss_in_if;
    import cwss_pkg::*;

    logic   valid;
    logic   ready;
    t_time  entry_time;
    t_price price;
    logic   last_entry;

    modport source (output valid, output entry_time, output price, output last_entry,
                    input ready);
    modport sink   (input valid, input entry_time, input price, input last_entry,
                    output ready);
endinterface

// ----- rtl/core/cwss_out_if.sv -----
// Output channel of the cheapest window start search: one result per beat.
// Depends on cwss_pkg for field widths.
`timescale 1ns / 1ps
interface cwss_out_if;
    import cwss_pkg::*;

    logic  valid;
    logic  ready;
    t_time chosen_start;
    logic  window_found;

    modport source (output valid, output chosen_start, output window_found, input ready);
    modport sink   (input valid, input chosen_start, input window_found, output ready);
endinterface

// ----- rtl/core/cwss_cell.sv -----
// One window cell: holds an entry time and the sum of the prices from here to the newest.
// Depends on cwss_pkg; chained in cheapest_window_start_search.
`timescale 1ns / 1ps
module cwss_cell (
    input  logic           i_clk,
    input  logic           i_adv,
    input  cwss_pkg::t_price i_price,
    input  cwss_pkg::t_cell  i_prev,
    output cwss_pkg::t_cell  o_cell
);
    import cwss_pkg::*;

    t_cell r_cell;
    t_cell n_cell;

    // Take the neighbour's time and add the new price to the neighbour's partial sum.
    always_comb begin
        n_cell.tstart = i_prev.tstart;
        n_cell.acc    = i_prev.acc + SUM_W'(i_price);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule

// ----- rtl/core/cwss_eval.sv -----
// Window evaluation stage: qualification, best-window tracking and the result register.
// Depends on cwss_pkg and cheapest_window_start_search_macros.svh.
`timescale 1ns / 1ps
`include "cheapest_window_start_search_macros.svh"
module cwss_eval (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cwss_pkg::t_cfg   i_cfg,
    input  cwss_pkg::t_stage i_stage,
    input  cwss_pkg::t_cand  i_cand,
    output logic            o_stall,
    cwss_out_if.source      o_out
);
    import cwss_pkg::*;

    logic  r_stopped;
    logic  n_stopped;
    logic  r_best_valid;
    logic  n_best_valid;
    t_sum  r_best_sum;
    t_sum  n_best_sum;
    t_time r_best_start;
    t_time n_best_start;
    logic  r_o_valid;
    t_time r_o_chosen;
    logic  r_o_found;

    logic  commit;
    logic  eligible;
    logic  ends_late;
    logic  starts_ok;
    logic  found;
    t_win  w;
    t_span span;
    t_time dflt;
    t_time chosen;

    // Hold a final beat while the previous result is still unread.
    assign o_stall = i_stage.valid && i_stage.last && r_o_valid && !o_out.ready;
    assign commit  = i_stage.valid && !o_stall;

    always_comb begin
        w         = window_len(i_cfg.window_hours);
        span      = window_span(w);
        ends_late = ({1'b0, i_cand.first_time} + (TIME_W + 1)'(span))
                    > {1'b0, i_cfg.stop_time};
        starts_ok = ({1'b0, i_cand.first_time} + (TIME_W + 1)'(MINUTES_PER_HOUR))
                    > {1'b0, i_cfg.earliest_time};
        eligible  = commit && (w != '0) && (32'(i_stage.cnt) >= 32'(w)) && !r_stopped;

        n_stopped    = r_stopped;
        n_best_valid = r_best_valid;
        n_best_sum   = r_best_sum;
        n_best_start = r_best_start;
        if (eligible) begin
            if (ends_late) begin
                n_stopped = 1'b1;
            end else if (starts_ok && (!r_best_valid || (i_cand.sum < r_best_sum))) begin
                n_best_valid = 1'b1;
                n_best_sum   = i_cand.sum;
                n_best_start = i_cand.first_time;
            end
        end

        dflt   = (i_cfg.stop_time >= TIME_W'(span)) ? (i_cfg.stop_time - TIME_W'(span)) : '0;
        found  = (w != '0) && (32'(i_stage.cnt) >= MIN_ENTRIES) && n_best_valid;
        if (w == '0) begin
            chosen = i_cfg.stop_time;
        end else if (found) begin
            chosen = n_best_start;
        end else begin
            chosen = dflt;
        end

        // Drop the list state once its result is out.
        if (commit && i_stage.last) begin
            n_stopped    = 1'b0;
            n_best_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped    <= 1'b0;
            r_best_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_stopped    <= n_stopped;
            r_best_valid <= n_best_valid;
            if (commit && i_stage.last) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_sum   <= n_best_sum;
        r_best_start <= n_best_start;
        if (commit && i_stage.last) begin
            r_o_chosen <= chosen;
            r_o_found  <= found;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.chosen_start = r_o_chosen;
    assign o_out.window_found = r_o_found;

    `CWSS_ASSERT_NOW(a_stall_needs_full_out, o_stall, r_o_valid)
    `CWSS_ASSERT_NOW(a_result_from_last, $rose(r_o_valid), $past(i_stage.valid && i_stage.last))
    `CWSS_ASSERT_NEXT(a_list_cleared, commit && i_stage.last, !r_best_valid && !r_stopped)
endmodule

// ----- rtl/core/cheapest_window_start_search.sv -----
// Cheapest window start search: a row of window cells shifts in one price beat per cycle unless stalled.
// The last entry is held in the stage register, then its result is loaded into the result register.
// Throughput: one entry per cycle; input stalls only while a final entry waits behind an
// unread result, since the evaluation stage has a single result register.
// Reset (i_rst_n, synchronous, active low) clears list state and result valid and loads
// a window of one hour with earliest and stop times of zero.
`timescale 1ns / 1ps
module cheapest_window_start_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cwss_in_if.sink                            i_in,
    cwss_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [cwss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cwss_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import cwss_pkg::*;

    t_cfg   r_cfg;
    t_cnt   r_cnt;
    t_cnt   n_cnt;
    t_stage r_stage;
    t_cand  cand;
    t_cell  cell_in  [MAX_WINDOW];
    t_cell  cell_out [MAX_WINDOW];
    logic   stall;
    logic   accept;
    t_win   w;
    logic [IDX_W-1:0] idx;

    assign i_in.ready = !stall;
    assign accept     = i_in.valid && !stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_hours  <= WIN_W'(1);
            r_cfg.earliest_time <= '0;
            r_cfg.stop_time     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW_HOURS: r_cfg.window_hours  <= i_cfg_data[WIN_W-1:0];
                CFG_START_TIME:   r_cfg.earliest_time <= i_cfg_data[TIME_W-1:0];
                CFG_STOP_TIME:    r_cfg.stop_time     <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Entry count saturates once it covers the longest window.
    assign n_cnt = (r_cnt == CNT_W'(CNT_MAX)) ? r_cnt : r_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_stage <= '0;
        end else begin
            if (accept) begin
                r_cnt        <= i_in.last_entry ? '0 : n_cnt;
                r_stage.last <= i_in.last_entry;
                r_stage.cnt  <= n_cnt;
            end
            if (!stall) begin
                r_stage.valid <= accept;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign cell_in[gi].tstart = i_in.entry_time;
                assign cell_in[gi].acc    = '0;
            end else begin : g_link
                assign cell_in[gi] = cell_out[gi-1];
            end
            cwss_cell u_cell (
                .i_clk   (i_clk),
                .i_adv   (accept),
                .i_price (i_in.price),
                .i_prev  (cell_in[gi]),
                .o_cell  (cell_out[gi])
            );
        end
    endgenerate

    // Cell w-1 holds the window's first time and the sum over the whole window.
    always_comb begin
        w   = window_len(r_cfg.window_hours);
        idx = (w == '0) ? '0 : IDX_W'(w - 1'b1);
        cand.first_time = cell_out[idx].tstart;
        cand.sum        = cell_out[idx].acc;
    end

    cwss_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_stage (r_stage),
        .i_cand  (cand),
        .o_stall (stall),
        .o_out   (o_out)
    );
endmodule
